FILE: hdl/ktr_pkg.sv
package ktr_pkg;

  localparam int unsigned ID_W     = 10;
  localparam int unsigned PRICE_W  = 32;
  localparam int unsigned CHG_W    = 32;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned RANK_W   = 4;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned ENTRY_W  = ID_W + CHG_W;

  localparam int unsigned MAX_STOCKS_DEF = 1024;
  localparam int unsigned TOP_MAX_DEF    = 16;

  localparam logic [CFG_W-1:0] TOP_COUNT_RST = 5'd10;

  // 100 * 65536
  localparam int unsigned      SCALE_W   = 23;
  localparam logic [SCALE_W-1:0] PCT_SCALE = 23'd6553600;
  localparam int unsigned      PROD_W    = PRICE_W + SCALE_W;
  localparam logic [CHG_W-1:0] CHG_MAX   = 32'h7FFF_FFFF;

  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [KIND_W-1:0] KIND_GAIN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOSE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

  localparam logic [0:0] REG_TOP_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OP_QUOTE,
    OP_CLEAR,
    OP_REJECT
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   id;
    logic [PRICE_W-1:0] price;
  } req_t;

  typedef struct packed {
    logic               start;
    logic [PROD_W-1:0]  dividend;
    logic [PRICE_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FPRD,
    S_MUL,
    S_DIV,
    S_SCAN,
    S_PLACE,
    S_SHIFT,
    S_PUT,
    S_PLAN,
    S_ERD,
    S_EOUT
  } back_state_e;

endpackage

FILE: hdl/top_k_movers_sorted_tracker_unit.sv
// Quote: the percent change comes from a serial divider (one bit a cycle); then the list
// is scanned to locate the entry, the entries in between are moved, and results are sent.
// Clear: list emptied, empty gainer and empty loser result; rejected quote: one empty result.
// One request in the back end at a time; a two-entry queue takes requests meanwhile.
// Reset: list empty, top_count 10, no clearing pass (membership follows the list count).
module top_k_movers_sorted_tracker_unit #(
  parameter int unsigned MAX_STOCKS = ktr_pkg::MAX_STOCKS_DEF,
  parameter int unsigned TOP_MAX    = ktr_pkg::TOP_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic [ktr_pkg::ID_W-1:0]          stock_id_i,
  input  logic [ktr_pkg::PRICE_W-1:0]       price_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ktr_pkg::KIND_W-1:0]        kind_o,
  output logic [ktr_pkg::RANK_W-1:0]        rank_o,
  output logic [ktr_pkg::ID_W-1:0]          mover_id_o,
  output logic signed [ktr_pkg::CHG_W-1:0]  change_percent_o,
  output logic                              entry_valid_o,
  output logic                              last_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ktr_pkg::APB_AW-1:0]        paddr,
  input  logic [ktr_pkg::APB_DW-1:0]        pwdata,
  output logic [ktr_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  logic [ktr_pkg::CFG_W-1:0] top_count_q;
  ktr_pkg::req_t             q_req;
  logic                      q_valid, q_ready;
  logic                      reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ktr_pkg::APB_AW-1:2] == ktr_pkg::REG_TOP_COUNT);
  assign prdata  = reg_hit ? ktr_pkg::APB_DW'(top_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q <= ktr_pkg::TOP_COUNT_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      top_count_q <= pwdata[ktr_pkg::CFG_W-1:0];
    end
  end

  ktr_front #(
    .MAX_STOCKS (MAX_STOCKS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .stock_id_i  (stock_id_i),
    .price_i     (price_i),
    .req_o       (q_req),
    .req_valid_o (q_valid),
    .req_ready_i (q_ready)
  );

  ktr_back #(
    .MAX_STOCKS (MAX_STOCKS),
    .TOP_MAX    (TOP_MAX)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (q_req),
    .req_valid_i      (q_valid),
    .req_ready_o      (q_ready),
    .top_count_i      (top_count_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .rank_o           (rank_o),
    .mover_id_o       (mover_id_o),
    .change_percent_o (change_percent_o),
    .entry_valid_o    (entry_valid_o),
    .last_o           (last_o)
  );

endmodule

FILE: hdl/ktr_front.sv
module ktr_front #(
  parameter int unsigned MAX_STOCKS = ktr_pkg::MAX_STOCKS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [ktr_pkg::ID_W-1:0]     stock_id_i,
  input  logic [ktr_pkg::PRICE_W-1:0]  price_i,
  output ktr_pkg::req_t                req_o,
  output logic                         req_valid_o,
  input  logic                         req_ready_i
);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);

  ktr_pkg::req_t slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [FW-1:0] fill_q, fill_d;
  ktr_pkg::req_t cls;
  logic          push, pop;

  always_comb begin
    cls.id    = stock_id_i;
    cls.price = price_i;
    if (command_i == ktr_pkg::CMD_CLEAR) begin
      cls.op = ktr_pkg::OP_CLEAR;
    end else if ((32'(stock_id_i) >= 32'(MAX_STOCKS)) || (price_i == '0)) begin
      cls.op = ktr_pkg::OP_REJECT;
    end else begin
      cls.op = ktr_pkg::OP_QUOTE;
    end
  end

  assign in_ready_o  = (fill_q != FW'(QUEUE_DEPTH));
  assign req_valid_o = (fill_q != '0);
  assign req_o       = slot_q[rp_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = req_valid_o & req_ready_i;

  always_comb begin
    wp_d   = wp_q;
    rp_d   = rp_q;
    fill_d = fill_q;
    if (push) begin
      wp_d = (32'(wp_q) == QUEUE_DEPTH - 1) ? '0 : PW'(wp_q + 1'b1);
    end
    if (pop) begin
      rp_d = (32'(rp_q) == QUEUE_DEPTH - 1) ? '0 : PW'(rp_q + 1'b1);
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      fill_q <= '0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= cls;
    end
  end

endmodule

FILE: hdl/ktr_div.sv
module ktr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ktr_pkg::div_req_t           req_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [ktr_pkg::PROD_W-1:0]  quot_o
);

  localparam int unsigned QW   = ktr_pkg::PROD_W;
  localparam int unsigned RW   = ktr_pkg::PRICE_W;
  localparam int unsigned CNTW = $clog2(QW + 1);

  logic [RW-1:0]   rem_q, rem_d, den_q, den_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [RW:0]     trial;

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[QW-1]};
    if (req_i.start) begin
      rem_d  = '0;
      den_d  = req_i.divisor;
      quo_d  = req_i.dividend;
      cnt_d  = CNTW'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = RW'(trial - {1'b0, den_q});
        quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = RW'(trial);
        quo_d = {quo_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

endmodule

FILE: hdl/ktr_back.sv
module ktr_back #(
  parameter int unsigned MAX_STOCKS = ktr_pkg::MAX_STOCKS_DEF,
  parameter int unsigned TOP_MAX    = ktr_pkg::TOP_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ktr_pkg::req_t                     req_i,
  input  logic                              req_valid_i,
  output logic                              req_ready_o,
  input  logic [ktr_pkg::CFG_W-1:0]         top_count_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ktr_pkg::KIND_W-1:0]        kind_o,
  output logic [ktr_pkg::RANK_W-1:0]        rank_o,
  output logic [ktr_pkg::ID_W-1:0]          mover_id_o,
  output logic signed [ktr_pkg::CHG_W-1:0]  change_percent_o,
  output logic                              entry_valid_o,
  output logic                              last_o
);

  localparam int unsigned AW  = $clog2(MAX_STOCKS);
  localparam int unsigned CW  = $clog2(MAX_STOCKS + 1);
  localparam int unsigned KW  = $clog2(TOP_MAX + 1);
  localparam int unsigned IW  = ktr_pkg::ID_W;
  localparam int unsigned XW  = ktr_pkg::CHG_W;
  localparam int unsigned PRW = ktr_pkg::PRICE_W;
  localparam int unsigned EW  = ktr_pkg::ENTRY_W;
  localparam int unsigned QW  = ktr_pkg::PROD_W;

  // ordered list {id, change} and reference prices
  logic [EW-1:0]  ord_mem [MAX_STOCKS];
  logic [PRW-1:0] fp_mem  [MAX_STOCKS];

  logic           ord_re, ord_we, fp_re, fp_we;
  logic [AW-1:0]  ord_raddr, ord_waddr, fp_addr;
  logic [EW-1:0]  ord_wdata, ord_rdata_q;
  logic [PRW-1:0] fp_rdata_q;

  ktr_pkg::back_state_e state_q, state_d;
  ktr_pkg::req_t        cur_q, cur_d;
  ktr_pkg::div_req_t    div_req;
  logic                 div_busy, div_done;
  logic [QW-1:0]        div_quot;

  logic [CW-1:0]  cnt_q, cnt_d, pos_q, pos_d, neg_q, neg_d;
  logic [CW-1:0]  a_q, a_d, r_q, r_d, p_q, p_d, s_q, s_d, rem_q, rem_d;
  logic [CW-1:0]  cc_q, cc_d, cz_q, cz_d;
  logic [AW-1:0]  rd_idx_q, rd_idx_d;
  logic           rd_vld_q, rd_vld_d, found_q, found_d, dn_q, dn_d;
  logic           negchg_q, negchg_d, emit_l_q, emit_l_d;
  logic           gval_q, gval_d, lval_q, lval_d;
  logic signed [XW-1:0] chg_q, chg_d, prev_q, prev_d;
  logic [QW-1:0]  prod_q, prod_d;
  logic [ktr_pkg::KIND_W-1:0] kind_q, kind_d;
  logic [KW-1:0]  glen_q, glen_d, llen_q, llen_d, c_q, c_d;

  logic                      out_valid_q, out_valid_d, out_load;
  logic [ktr_pkg::KIND_W-1:0] o_kind_q, o_kind_d;
  logic [ktr_pkg::RANK_W-1:0] o_rank_q, o_rank_d;
  logic [IW-1:0]             o_id_q, o_id_d;
  logic signed [XW-1:0]      o_chg_q, o_chg_d;
  logic                      o_ev_q, o_ev_d, o_last_q, o_last_d;

  logic [KW-1:0]  k, cur_len, g_cnt, l_cnt;
  logic           cur_val, out_free, g_hit, l_hit, at_end;
  logic [PRW-1:0] mag;
  logic [IW-1:0]  rid;
  logic signed [XW-1:0] rchg;
  logic [CW-1:0]  pn, rn, pos_n, neg_n;

  ktr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    if (top_count_i == '0) begin
      k = KW'(1);
    end else if (32'(top_count_i) > TOP_MAX) begin
      k = KW'(TOP_MAX);
    end else begin
      k = KW'(top_count_i);
    end
  end

  assign rid      = ord_rdata_q[EW-1:XW];
  assign rchg     = signed'(ord_rdata_q[XW-1:0]);
  assign cur_len  = (kind_q == ktr_pkg::KIND_LOSE) ? llen_q : glen_q;
  assign cur_val  = (kind_q == ktr_pkg::KIND_LOSE) ? lval_q : gval_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign at_end   = ((c_q + KW'(1)) == cur_len);

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    neg_d    = neg_q;
    a_d      = a_q;
    r_d      = r_q;
    p_d      = p_q;
    s_d      = s_q;
    rem_d    = rem_q;
    cc_d     = cc_q;
    cz_d     = cz_q;
    rd_idx_d = rd_idx_q;
    rd_vld_d = rd_vld_q;
    found_d  = found_q;
    dn_d     = dn_q;
    negchg_d = negchg_q;
    emit_l_d = emit_l_q;
    gval_d   = gval_q;
    lval_d   = lval_q;
    chg_d    = chg_q;
    prev_d   = prev_q;
    prod_d   = prod_q;
    kind_d   = kind_q;
    glen_d   = glen_q;
    llen_d   = llen_q;
    c_d      = c_q;
    req_ready_o = 1'b0;
    ord_re    = 1'b0;
    ord_we    = 1'b0;
    ord_raddr = '0;
    ord_waddr = '0;
    ord_wdata = '0;
    fp_re     = 1'b0;
    fp_we     = 1'b0;
    fp_addr   = AW'(cur_q.id);
    div_req.start    = 1'b0;
    div_req.dividend = prod_q;
    div_req.divisor  = fp_rdata_q;
    out_load = 1'b0;
    o_kind_d = o_kind_q;
    o_rank_d = o_rank_q;
    o_id_d   = o_id_q;
    o_chg_d  = o_chg_q;
    o_ev_d   = o_ev_q;
    o_last_d = o_last_q;
    mag   = '0;
    pn    = '0;
    rn    = '0;
    pos_n = pos_q;
    neg_n = neg_q;
    g_hit = 1'b0;
    l_hit = 1'b0;
    g_cnt = '0;
    l_cnt = '0;

    case (state_q)
      ktr_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cur_d  = req_i;
          c_d    = '0;
          glen_d = KW'(1);
          llen_d = KW'(1);
          gval_d = 1'b0;
          lval_d = 1'b0;
          case (req_i.op)
            ktr_pkg::OP_CLEAR: begin
              cnt_d    = '0;
              pos_d    = '0;
              neg_d    = '0;
              kind_d   = ktr_pkg::KIND_GAIN;
              emit_l_d = 1'b1;
              state_d  = ktr_pkg::S_ERD;
            end
            ktr_pkg::OP_REJECT: begin
              kind_d   = ktr_pkg::KIND_REJECT;
              emit_l_d = 1'b0;
              state_d  = ktr_pkg::S_ERD;
            end
            ktr_pkg::OP_QUOTE: begin
              fp_re   = 1'b1;
              fp_addr = AW'(req_i.id);
              state_d = ktr_pkg::S_FPRD;
            end
            default: begin
              state_d = ktr_pkg::S_IDLE;
            end
          endcase
        end
      end

      ktr_pkg::S_FPRD: begin
        negchg_d = (cur_q.price < fp_rdata_q);
        mag      = negchg_d ? (fp_rdata_q - cur_q.price) : (cur_q.price - fp_rdata_q);
        prod_d   = mag * ktr_pkg::PCT_SCALE;
        state_d  = ktr_pkg::S_MUL;
      end

      ktr_pkg::S_MUL: begin
        div_req.start = 1'b1;
        state_d       = ktr_pkg::S_DIV;
      end

      ktr_pkg::S_DIV: begin
        if (div_done) begin
          if (negchg_q) begin
            chg_d = -signed'(div_quot[XW-1:0]);
          end else if (div_quot > QW'(ktr_pkg::CHG_MAX)) begin
            chg_d = signed'(ktr_pkg::CHG_MAX);
          end else begin
            chg_d = signed'(div_quot[XW-1:0]);
          end
          a_d      = '0;
          rd_vld_d = 1'b0;
          found_d  = 1'b0;
          cc_d     = '0;
          cz_d     = '0;
          state_d  = ktr_pkg::S_SCAN;
        end
      end

      ktr_pkg::S_SCAN: begin
        if (a_q < cnt_q) begin
          ord_re    = 1'b1;
          ord_raddr = AW'(a_q);
          a_d       = a_q + 1'b1;
          rd_vld_d  = 1'b1;
          rd_idx_d  = AW'(a_q);
        end else begin
          rd_vld_d = 1'b0;
        end
        if (rd_vld_q) begin
          if (rid == cur_q.id) begin
            found_d = 1'b1;
            r_d     = CW'(rd_idx_q);
            prev_d  = rchg;
          end else begin
            if (rchg >= chg_q) begin
              cc_d = cc_q + 1'b1;
            end
            if (rchg >= 0) begin
              cz_d = cz_q + 1'b1;
            end
          end
        end
        if ((a_q == cnt_q) && !rd_vld_q) begin
          state_d = ktr_pkg::S_PLACE;
        end
      end

      ktr_pkg::S_PLACE: begin
        if (found_q) begin
          pn = cc_q;
          rn = r_q;
        end else begin
          pn     = cz_q;
          rn     = cnt_q;
          chg_d  = '0;
          prev_d = '0;
          cnt_d  = cnt_q + 1'b1;
          fp_we  = 1'b1;
        end
        p_d   = pn;
        r_d   = rn;
        dn_d  = (pn < rn);
        rem_d = (pn < rn) ? (rn - pn) : (pn - rn);
        s_d   = (pn < rn) ? (rn - 1'b1) : (rn + 1'b1);
        rd_vld_d = 1'b0;
        state_d  = ktr_pkg::S_SHIFT;
      end

      ktr_pkg::S_SHIFT: begin
        if (rem_q != '0) begin
          ord_re    = 1'b1;
          ord_raddr = AW'(s_q);
          rd_idx_d  = AW'(s_q);
          rd_vld_d  = 1'b1;
          rem_d     = rem_q - 1'b1;
          s_d       = dn_q ? (s_q - 1'b1) : (s_q + 1'b1);
        end else begin
          rd_vld_d = 1'b0;
        end
        if (rd_vld_q) begin
          ord_we    = 1'b1;
          ord_waddr = dn_q ? AW'(rd_idx_q + 1'b1) : AW'(rd_idx_q - 1'b1);
          ord_wdata = ord_rdata_q;
        end
        if ((rem_q == '0) && !rd_vld_q) begin
          state_d = ktr_pkg::S_PUT;
        end
      end

      ktr_pkg::S_PUT: begin
        ord_we    = 1'b1;
        ord_waddr = AW'(p_q);
        ord_wdata = {cur_q.id, chg_q};
        if (found_q && (prev_q > 0)) begin
          pos_n = pos_n - 1'b1;
        end
        if (found_q && (prev_q < 0)) begin
          neg_n = neg_n - 1'b1;
        end
        if (chg_q > 0) begin
          pos_n = pos_n + 1'b1;
        end
        if (chg_q < 0) begin
          neg_n = neg_n + 1'b1;
        end
        pos_d   = pos_n;
        neg_d   = neg_n;
        state_d = ktr_pkg::S_PLAN;
      end

      ktr_pkg::S_PLAN: begin
        g_hit = (found_q && (prev_q > 0) && (32'(r_q) < 32'(k)))
             || ((chg_q > 0) && (32'(p_q) < 32'(k)));
        l_hit = (found_q && (prev_q < 0) && (32'(cnt_q - r_q) <= 32'(k)))
             || ((chg_q < 0) && (32'(cnt_q - p_q) <= 32'(k)));
        g_cnt  = (32'(pos_q) < 32'(k)) ? KW'(pos_q) : k;
        l_cnt  = (32'(neg_q) < 32'(k)) ? KW'(neg_q) : k;
        gval_d = (g_cnt != '0);
        lval_d = (l_cnt != '0);
        glen_d = (g_cnt != '0) ? g_cnt : KW'(1);
        llen_d = (l_cnt != '0) ? l_cnt : KW'(1);
        c_d    = '0;
        if (g_hit) begin
          kind_d   = ktr_pkg::KIND_GAIN;
          emit_l_d = l_hit;
          state_d  = ktr_pkg::S_ERD;
        end else if (l_hit) begin
          kind_d   = ktr_pkg::KIND_LOSE;
          emit_l_d = 1'b0;
          state_d  = ktr_pkg::S_ERD;
        end else begin
          state_d = ktr_pkg::S_IDLE;
        end
      end

      ktr_pkg::S_ERD: begin
        if (cur_val) begin
          ord_re    = 1'b1;
          ord_raddr = (kind_q == ktr_pkg::KIND_LOSE)
                    ? AW'(cnt_q - CW'(c_q) - CW'(1)) : AW'(c_q);
        end
        state_d = ktr_pkg::S_EOUT;
      end

      ktr_pkg::S_EOUT: begin
        if (out_free) begin
          out_load = 1'b1;
          o_kind_d = kind_q;
          o_rank_d = ktr_pkg::RANK_W'(c_q);
          o_id_d   = cur_val ? rid : '0;
          o_chg_d  = cur_val ? rchg : '0;
          o_ev_d   = cur_val;
          o_last_d = at_end && !((kind_q == ktr_pkg::KIND_GAIN) && emit_l_q);
          if (at_end) begin
            if ((kind_q == ktr_pkg::KIND_GAIN) && emit_l_q) begin
              kind_d   = ktr_pkg::KIND_LOSE;
              emit_l_d = 1'b0;
              c_d      = '0;
              state_d  = ktr_pkg::S_ERD;
            end else begin
              state_d = ktr_pkg::S_IDLE;
            end
          end else begin
            c_d     = c_q + KW'(1);
            state_d = ktr_pkg::S_ERD;
          end
        end
      end

      default: begin
        state_d = ktr_pkg::S_IDLE;
      end
    endcase

    out_valid_d = out_load ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    if (ord_re) begin
      ord_rdata_q <= ord_mem[ord_raddr];
    end
    if (fp_we) begin
      fp_mem[fp_addr] <= cur_q.price;
    end
    if (fp_re) begin
      fp_rdata_q <= fp_mem[fp_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ktr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pos_q       <= '0;
      neg_q       <= '0;
      a_q         <= '0;
      rem_q       <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      emit_l_q    <= 1'b0;
      kind_q      <= ktr_pkg::KIND_GAIN;
      c_q         <= '0;
      glen_q      <= KW'(1);
      llen_q      <= KW'(1);
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      neg_q       <= neg_d;
      a_q         <= a_d;
      rem_q       <= rem_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      emit_l_q    <= emit_l_d;
      kind_q      <= kind_d;
      c_q         <= c_d;
      glen_q      <= glen_d;
      llen_q      <= llen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    r_q      <= r_d;
    p_q      <= p_d;
    s_q      <= s_d;
    cc_q     <= cc_d;
    cz_q     <= cz_d;
    rd_idx_q <= rd_idx_d;
    dn_q     <= dn_d;
    negchg_q <= negchg_d;
    gval_q   <= gval_d;
    lval_q   <= lval_d;
    chg_q    <= chg_d;
    prev_q   <= prev_d;
    prod_q   <= prod_d;
    o_kind_q <= o_kind_d;
    o_rank_q <= o_rank_d;
    o_id_q   <= o_id_d;
    o_chg_q  <= o_chg_d;
    o_ev_q   <= o_ev_d;
    o_last_q <= o_last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = o_kind_q;
  assign rank_o           = o_rank_q;
  assign mover_id_o       = o_id_q;
  assign change_percent_o = o_chg_q;
  assign entry_valid_o    = o_ev_q;
  assign last_o           = o_last_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_STOCKS)
    else $error("list count beyond capacity");

  a_sign_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(pos_q) + 32'(neg_q)) <= 32'(cnt_q))
    else $error("gainer and loser counts exceed list size");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == ktr_pkg::S_DIV))
    else $error("divider running outside divide state");

  a_reject_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == ktr_pkg::KIND_REJECT)) |-> (last_o && !entry_valid_o))
    else $error("rejection not a single empty result");
`endif

endmodule
